[rtl/core/mlq_pkg.sv]
// ----------------------------------------------------------------------------
// mlq_pkg
// Shared types, widths and register indexes for the multibit level quantizer.
// ----------------------------------------------------------------------------
package mlq_pkg;

  localparam int SCALE_REGS = 4;
  localparam int SCALE_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int WORD_W     = 32;
  localparam int POS_W      = 5;
  localparam int CODE_W     = SCALE_REGS;
  localparam int STEP_W     = CODE_W + 1;
  localparam int LVL_W      = 20;
  localparam int DIST_W     = LVL_W;
  localparam int BITS_W     = 3;
  localparam int PLANE_W    = 2;
  localparam int WIDX_W     = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SEL_W      = 2;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORD_W - 1);

  localparam logic [CFG_ADDR_W-1:0] REG_BITS   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE0 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE3 = 3'd4;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;
  localparam logic [BITS_W-1:0]  BITS_RESET  = 3'd1;

  typedef logic [SCALE_REGS-1:0][SCALE_W-1:0] scale_vec_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_INIT,
    SR_SCAN,
    SR_DONE
  } search_state_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              last;
  } search_res_t;

  // index of the lowest set bit, value must be nonzero
  function automatic logic [SEL_W-1:0] trailing_zeros(input logic [CODE_W-1:0] v);
    logic [SEL_W-1:0] r;
    r = 2'd0;
    if (v[0]) begin
      r = 2'd0;
    end else if (v[1]) begin
      r = 2'd1;
    end else if (v[2]) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

endpackage

[rtl/core/mlq_in_if.sv]
// ----------------------------------------------------------------------------
// mlq_in_if
// Sample channel: valid/ready handshake with one Q4.12 sample per beat.
// ----------------------------------------------------------------------------
interface mlq_in_if;
  import mlq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);

endinterface

[rtl/core/mlq_out_if.sv]
// ----------------------------------------------------------------------------
// mlq_out_if
// Packed word channel: one bit-plane word per beat.
// ----------------------------------------------------------------------------
interface mlq_out_if;
  import mlq_pkg::*;

  logic               valid;
  logic               ready;
  logic [PLANE_W-1:0] plane;
  logic [WIDX_W-1:0]  word_index;
  logic [WORD_W-1:0]  word;
  logic               run_last;
  logic               vector_end;

  modport source (output valid, output plane, output word_index, output word,
                  output run_last, output vector_end, input ready);
  modport sink   (input valid, input plane, input word_index, input word,
                  input run_last, input vector_end, output ready);

endinterface

[rtl/core/multibit_level_quantize_pack_core.sv]
// ----------------------------------------------------------------------------
// multibit_level_quantize_pack_core
// Quantizes Q4.12 samples to the nearest of 2^n levels and packs the code
// bits into 32-bit bit-plane words.
// ----------------------------------------------------------------------------
// A new sample is accepted only after the search of the previous one is
// done; n below is the active bit count. In the search unit a single adder
// first builds the level of code zero, one active scale at a time, then
// walks all 2^n codes in Gray order, one code a cycle, against one distance
// comparator. When a sample closes a group of 32 or carries the last mark,
// the n plane words follow, plane 0 first, one beat each, and no sample is
// taken until the last of them has been accepted. Configuration writes take
// effect at the next clock edge and belong to idle time.
module multibit_level_quantize_pack_core
  import mlq_pkg::*;
#(
  parameter int MAX_BITS   = 4,
  parameter int MAX_GROUPS = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  mlq_in_if.sink                in_bus,
  mlq_out_if.source             out_bus
);

  localparam int PLANES = (MAX_BITS < SCALE_REGS) ? MAX_BITS : SCALE_REGS;
  localparam logic [BITS_W-1:0] N_LIMIT = BITS_W'(PLANES);

  logic [BITS_W-1:0] bits_r, bits_nxt;
  scale_vec_t        scale_r, scale_nxt;

  logic [BITS_W-1:0] n_eff;
  logic              start;
  logic              search_idle;
  logic              pack_busy;
  search_res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= BITS_RESET;
      scale_r <= {SCALE_REGS{SCALE_RESET}};
    end else begin
      bits_r  <= bits_nxt;
      scale_r <= scale_nxt;
    end
  end

  always_comb begin
    bits_nxt  = bits_r;
    scale_nxt = scale_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_BITS:   bits_nxt     = cfg_wdata[BITS_W-1:0];
        REG_SCALE0: scale_nxt[0] = cfg_wdata[SCALE_W-1:0];
        REG_SCALE1: scale_nxt[1] = cfg_wdata[SCALE_W-1:0];
        REG_SCALE2: scale_nxt[2] = cfg_wdata[SCALE_W-1:0];
        REG_SCALE3: scale_nxt[3] = cfg_wdata[SCALE_W-1:0];
        default: begin
          bits_nxt = bits_r;
        end
      endcase
    end
  end

  // zero acts as one bit, large counts clamp to the plane count
  always_comb begin
    if (bits_r == '0) begin
      n_eff = BITS_W'(1);
    end else if (bits_r > N_LIMIT) begin
      n_eff = N_LIMIT;
    end else begin
      n_eff = bits_r;
    end
  end

  assign in_bus.ready = search_idle && !pack_busy;
  assign start        = in_bus.valid && in_bus.ready;

  mlq_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .sample_i (in_bus.sample),
    .last_i   (in_bus.last),
    .n_i      (n_eff),
    .scales_i (scale_r),
    .idle_o   (search_idle),
    .res_o    (res)
  );

  mlq_pack #(
    .PLANES     (PLANES),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_i   (res),
    .n_i     (n_eff),
    .busy_o  (pack_busy),
    .out_bus (out_bus)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_bus.ready)
    else $error("sample taken while the previous one is still in search");

endmodule

[rtl/core/mlq_search.sv]
// ----------------------------------------------------------------------------
// mlq_search
// Nearest-level search: one adder walks the codes in Gray order, one
// comparator keeps the best (distance, level, code).
// ----------------------------------------------------------------------------
module mlq_search
  import mlq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  input  logic [BITS_W-1:0]          n_i,
  input  scale_vec_t                 scales_i,
  output logic                       idle_o,
  output search_res_t                res_o
);

  search_state_t              state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                       last_r, last_nxt;
  logic [SEL_W-1:0]           bidx_r, bidx_nxt;
  logic [CODE_W-1:0]          k_r, k_nxt;
  logic signed [LVL_W-1:0]    level_r, level_nxt;
  logic [DIST_W-1:0]          best_dist_r, best_dist_nxt;
  logic signed [LVL_W-1:0]    best_lvl_r, best_lvl_nxt;
  logic [CODE_W-1:0]          best_code_r, best_code_nxt;

  logic [STEP_W-1:0]          last_k;
  logic [BITS_W-1:0]          n_m1;
  logic [CODE_W-1:0]          gray;
  logic [CODE_W-1:0]          kp1;
  logic [CODE_W-1:0]          gray_next;
  logic [SEL_W-1:0]           flip;
  logic [SEL_W-1:0]           sel_idx;
  logic signed [LVL_W-1:0]    scale_ext;
  logic signed [LVL_W-1:0]    operand;
  logic signed [LVL_W-1:0]    level_sum;
  logic signed [LVL_W:0]      diff;
  logic [LVL_W:0]             diff_abs;
  logic [DIST_W-1:0]          cur_dist;
  logic                       better;

  assign last_k    = STEP_W'((STEP_W'(1) << n_i) - STEP_W'(1));
  assign n_m1      = n_i - BITS_W'(1);
  assign gray      = k_r ^ (k_r >> 1);
  assign kp1       = k_r + CODE_W'(1);
  assign gray_next = kp1 ^ (kp1 >> 1);
  assign flip      = trailing_zeros(kp1);

  // one scale read port, shared by the offset build-up and the code walk
  assign sel_idx   = (state_r == SR_INIT) ? bidx_r : flip;
  assign scale_ext = $signed({{(LVL_W-SCALE_W){1'b0}}, scales_i[sel_idx]});

  always_comb begin
    if (state_r == SR_INIT) begin
      operand = -scale_ext;
    end else if (gray_next[flip]) begin
      operand = scale_ext <<< 1;
    end else begin
      operand = -(scale_ext <<< 1);
    end
  end

  assign level_sum = level_r + operand;

  assign diff     = $signed({{(LVL_W+1-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r})
                  - $signed({level_r[LVL_W-1], level_r});
  assign diff_abs = diff[LVL_W] ? (LVL_W+1)'(0) - diff : diff;
  assign cur_dist = diff_abs[DIST_W-1:0];

  // lexicographic order on distance, then level, then code
  assign better = (k_r == '0) || (cur_dist < best_dist_r) ||
                  ((cur_dist == best_dist_r) &&
                   ((level_r < best_lvl_r) ||
                    ((level_r == best_lvl_r) && (gray < best_code_r))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sample_r    <= sample_nxt;
    last_r      <= last_nxt;
    bidx_r      <= bidx_nxt;
    k_r         <= k_nxt;
    level_r     <= level_nxt;
    best_dist_r <= best_dist_nxt;
    best_lvl_r  <= best_lvl_nxt;
    best_code_r <= best_code_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    bidx_nxt      = bidx_r;
    k_nxt         = k_r;
    level_nxt     = level_r;
    best_dist_nxt = best_dist_r;
    best_lvl_nxt  = best_lvl_r;
    best_code_nxt = best_code_r;
    res_o         = '0;
    case (state_r)
      SR_IDLE: begin
        if (start_i) begin
          sample_nxt = sample_i;
          last_nxt   = last_i;
          level_nxt  = '0;
          bidx_nxt   = '0;
          state_nxt  = SR_INIT;
        end
      end
      SR_INIT: begin
        // level of code zero is minus the sum of the active scales
        level_nxt = level_sum;
        bidx_nxt  = bidx_r + SEL_W'(1);
        if ({1'b0, bidx_r} == n_m1) begin
          k_nxt     = '0;
          state_nxt = SR_SCAN;
        end
      end
      SR_SCAN: begin
        if (better) begin
          best_dist_nxt = cur_dist;
          best_lvl_nxt  = level_r;
          best_code_nxt = gray;
        end
        if ({1'b0, k_r} == last_k) begin
          state_nxt = SR_DONE;
        end else begin
          level_nxt = level_sum;
          k_nxt     = kp1;
        end
      end
      SR_DONE: begin
        res_o.valid = 1'b1;
        res_o.code  = best_code_r;
        res_o.last  = last_r;
        state_nxt   = SR_IDLE;
      end
      default: begin
        state_nxt = SR_IDLE;
      end
    endcase
  end

  assign idle_o = (state_r == SR_IDLE);

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SR_SCAN) |-> ({1'b0, k_r} <= last_k))
    else $error("code walk ran past the last code");

  a_code_fits: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.valid |-> ((STEP_W'(res_o.code) >> n_i) == '0))
    else $error("chosen code uses bits above the active count");

endmodule

[rtl/core/mlq_pack.sv]
// ----------------------------------------------------------------------------
// mlq_pack
// Bit-plane packer: sets code bits into plane words and emits one word per
// active plane when a group fills or the vector ends.
// ----------------------------------------------------------------------------
module mlq_pack
  import mlq_pkg::*;
#(
  parameter int PLANES     = 4,
  parameter int MAX_GROUPS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  search_res_t       res_i,
  input  logic [BITS_W-1:0] n_i,
  output logic              busy_o,
  mlq_out_if.source         out_bus
);

  localparam int PIW = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam logic [GW-1:0] GRP_LAST = GW'(MAX_GROUPS - 1);

  logic [PLANES-1:0][WORD_W-1:0] words_r, words_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [GW-1:0]                 grp_r, grp_nxt;
  logic                          emit_r, emit_nxt;
  logic [PIW-1:0]                p_r, p_nxt;
  logic                          vend_r, vend_nxt;

  logic                          final_plane;
  logic [GW+WIDX_W-1:0]          grp_ext;

  assign final_plane = (BITS_W'(p_r) == n_i - BITS_W'(1));
  assign grp_ext     = {{WIDX_W{1'b0}}, grp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
      pos_r   <= '0;
      grp_r   <= '0;
      emit_r  <= 1'b0;
      p_r     <= '0;
      vend_r  <= 1'b0;
    end else begin
      words_r <= words_nxt;
      pos_r   <= pos_nxt;
      grp_r   <= grp_nxt;
      emit_r  <= emit_nxt;
      p_r     <= p_nxt;
      vend_r  <= vend_nxt;
    end
  end

  always_comb begin
    words_nxt = words_r;
    pos_nxt   = pos_r;
    grp_nxt   = grp_r;
    emit_nxt  = emit_r;
    p_nxt     = p_r;
    vend_nxt  = vend_r;
    if (res_i.valid) begin
      for (int b = 0; b < PLANES; b++) begin
        if (BITS_W'(b) < n_i) begin
          words_nxt[b][pos_r] = words_r[b][pos_r] | res_i.code[b];
        end
      end
      if ((pos_r == POS_LAST) || res_i.last) begin
        emit_nxt = 1'b1;
        p_nxt    = '0;
        vend_nxt = res_i.last;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
    if (emit_r && out_bus.ready) begin
      if (final_plane) begin
        emit_nxt  = 1'b0;
        words_nxt = '0;
        pos_nxt   = '0;
        if (vend_r || (grp_r == GRP_LAST)) begin
          grp_nxt = '0;
        end else begin
          grp_nxt = grp_r + GW'(1);
        end
      end else begin
        p_nxt = p_r + PIW'(1);
      end
    end
  end

  assign out_bus.valid      = emit_r;
  assign out_bus.plane      = PLANE_W'(p_r);
  assign out_bus.word_index = grp_ext[WIDX_W-1:0];
  assign out_bus.word       = words_r[p_r];
  assign out_bus.run_last   = final_plane;
  assign out_bus.vector_end = vend_r;
  assign busy_o             = emit_r;

  a_plane_active: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> (BITS_W'(p_r) < n_i))
    else $error("emitting a plane above the active bit count");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for multibit_level_quantize_pack_core. A bit-accurate model of the
// nearest-level search and bit-plane packing predicts every plane word. Words
// are checked in order as they leave the block. Stimulus is a directed set of
// corner samples, then random vectors over several register settings and
// handshake profiles, including a vector that spans several groups.
// ----------------------------------------------------------------------------
module tb;
  import mlq_pkg::*;

  localparam int QZ_MAX_BITS   = 4;
  localparam int QZ_MAX_GROUPS = 128;
  // drain margin, ample for the longest sample search
  localparam int SETTLE_CYCLES = 48;

  localparam logic [CFG_ADDR_W-1:0] SCALE_IDX [SCALE_REGS] =
    '{REG_SCALE0, REG_SCALE1, REG_SCALE2, REG_SCALE3};

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [WIDX_W-1:0]  word_index;
    logic [WORD_W-1:0]  word;
    logic               run_last;
    logic               vector_end;
  } word_beat_t;

  class plane_word_model;
    logic [BITS_W-1:0]  bits_reg;
    logic [SCALE_W-1:0] scale_reg [SCALE_REGS];
    logic [WORD_W-1:0]  plane_acc [SCALE_REGS];
    int                 bit_pos;
    int                 group_idx;
    word_beat_t         pending_words [$];
    int                 errors;

    function new();
      bits_reg = BITS_RESET;
      for (int b = 0; b < SCALE_REGS; b++) begin
        scale_reg[b] = SCALE_RESET;
        plane_acc[b] = '0;
      end
      bit_pos   = 0;
      group_idx = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_BITS:   bits_reg     = val[BITS_W-1:0];
        REG_SCALE0: scale_reg[0] = val;
        REG_SCALE1: scale_reg[1] = val;
        REG_SCALE2: scale_reg[2] = val;
        REG_SCALE3: scale_reg[3] = val;
        default: ;
      endcase
    endfunction

    function int active_bits();
      int n;
      n = int'(bits_reg);
      if (n < 1) n = 1;
      if (n > QZ_MAX_BITS) n = QZ_MAX_BITS;
      if (n > SCALE_REGS) n = SCALE_REGS;
      return n;
    endfunction

    function int level_for(int code, int n);
      int sum;
      sum = 0;
      for (int b = 0; b < n; b++) begin
        if ((code >> b) & 1) sum += int'(scale_reg[b]);
        else sum -= int'(scale_reg[b]);
      end
      return sum;
    endfunction

    // full search, ties go to the lower level, equal levels to the lowest code
    function int nearest_code(int s, int n);
      int best, best_lvl, best_dist, lv, d;
      best      = 0;
      best_lvl  = level_for(0, n);
      best_dist = s - best_lvl;
      if (best_dist < 0) best_dist = -best_dist;
      for (int c = 1; c < (1 << n); c++) begin
        lv = level_for(c, n);
        d  = s - lv;
        if (d < 0) d = -d;
        if (d < best_dist || (d == best_dist && lv < best_lvl)) begin
          best      = c;
          best_dist = d;
          best_lvl  = lv;
        end
      end
      return best;
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s, logic is_last);
      int n, code;
      word_beat_t w;
      n    = active_bits();
      code = nearest_code(int'(s), n);
      for (int b = 0; b < n; b++) begin
        if ((code >> b) & 1) plane_acc[b][bit_pos] = 1'b1;
      end
      if (bit_pos == WORD_W - 1 || is_last) begin
        for (int b = 0; b < n; b++) begin
          w.plane      = PLANE_W'(b);
          w.word_index = WIDX_W'(group_idx);
          w.word       = plane_acc[b];
          w.run_last   = (b == n - 1);
          w.vector_end = is_last;
          pending_words.push_back(w);
        end
        for (int b = 0; b < SCALE_REGS; b++) plane_acc[b] = '0;
        bit_pos = 0;
        if (is_last || group_idx + 1 >= QZ_MAX_GROUPS) group_idx = 0;
        else group_idx = group_idx + 1;
      end else begin
        bit_pos = bit_pos + 1;
      end
    endfunction

    function void check_word(word_beat_t got);
      word_beat_t want;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t unexpected word: plane %0d index %0d word %h run_last %b vector_end %b",
                 $time, got.plane, got.word_index, got.word, got.run_last, got.vector_end);
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t word mismatch: expected plane %0d index %0d word %h run_last %b vector_end %b",
                 $time, want.plane, want.word_index, want.word, want.run_last, want.vector_end);
        $display("%0t                got      plane %0d index %0d word %h run_last %b vector_end %b",
                 $time, got.plane, got.word_index, got.word, got.run_last, got.vector_end);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    idle_pct;
  int                    stall_pct;

  mlq_in_if  in_bus ();
  mlq_out_if out_bus ();

  plane_word_model planes = new();

  multibit_level_quantize_pack_core #(
    .MAX_BITS  (QZ_MAX_BITS),
    .MAX_GROUPS(QZ_MAX_GROUPS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus.sink),
    .out_bus  (out_bus.source)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stalls, every accepted beat goes to the checker
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n === 1'b1 && out_bus.valid && out_bus.ready) begin
      planes.check_word('{plane: out_bus.plane, word_index: out_bus.word_index,
                          word: out_bus.word, run_last: out_bus.run_last,
                          vector_end: out_bus.vector_end});
    end
  end

  task automatic set_profile(input int k);
    case (k)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 72; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 72; end
      default: begin idle_pct = 26; stall_pct = 26; end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    planes.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [BITS_W-1:0] bits, input logic [SCALE_W-1:0] s0,
                              input logic [SCALE_W-1:0] s1, input logic [SCALE_W-1:0] s2,
                              input logic [SCALE_W-1:0] s3);
    write_reg(REG_BITS, CFG_DATA_W'(bits));
    write_reg(SCALE_IDX[0], s0);
    write_reg(SCALE_IDX[1], s1);
    write_reg(SCALE_IDX[2], s2);
    write_reg(SCALE_IDX[3], s3);
  endtask

  task automatic random_config();
    logic [SCALE_W-1:0] sc [SCALE_REGS];
    for (int b = 0; b < SCALE_REGS; b++) begin
      case ($urandom_range(5))
        0: sc[b] = '0;
        1: sc[b] = '1;
        2: sc[b] = (b == 0) ? SCALE_W'($urandom_range(8191)) : sc[b-1];
        3: sc[b] = SCALE_W'($urandom);
        default: sc[b] = SCALE_W'($urandom_range(8191));
      endcase
    end
    apply_config(BITS_W'($urandom_range(7)), sc[0], sc[1], sc[2], sc[3]);
  endtask

  // beat stays valid into the next call unless that call opens a gap
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= s;
    in_bus.last   <= is_last;
    do @(posedge clk); while (!in_bus.ready);
    planes.take_sample(s, is_last);
  endtask

  // stop sending and wait until the block has drained
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (planes.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int n, v;
    n = planes.active_bits();
    case ($urandom_range(9))
      0, 1, 2: v = int'($signed(SAMPLE_W'($urandom)));
      3, 4, 5: v = planes.level_for($urandom_range((1 << n) - 1), n)
                   + int'($urandom_range(8)) - 4;
      6, 7: v = ((planes.level_for($urandom_range((1 << n) - 1), n)
                 + planes.level_for($urandom_range((1 << n) - 1), n)) >>> 1)
                + int'($urandom_range(2)) - 1;
      8: begin
        case ($urandom_range(2))
          0: v = 32767;
          1: v = -32768;
          default: v = 0;
        endcase
      end
      default: v = int'($urandom_range(128)) - 64;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  initial begin
    idle_pct       = 0;
    stall_pct      = 0;
    in_bus.valid  <= 1'b0;
    in_bus.sample <= '0;
    in_bus.last   <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= REG_BITS;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting, one bit at +-1.0: zero sits on the midpoint
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd4096, 1'b0);
    send_sample(-16'sd4096, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    settle();

    // two bits, codes 1 and 2 share level zero
    apply_config(3'd2, 16'd2048, 16'd2048, 16'd4096, 16'd4096);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd2048, 1'b0);
    send_sample(16'sd2048, 1'b0);
    send_sample(16'sd6000, 1'b1);
    settle();

    // bit count zero acts as one, all levels collapse to zero
    apply_config(3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'sd12345, 1'b0);
    send_sample(16'sh8000, 1'b1);
    settle();

    // bit count above the limit acts as four, extreme scales
    apply_config(3'd7, 16'hffff, 16'd0, 16'hffff, 16'd1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      set_profile(ph % 4);
      if (ph == 5) begin
        // one vector over three full groups so the group index counts up
        apply_config(3'd1, SCALE_W'($urandom_range(8191)), 16'd4096, 16'd4096, 16'd4096);
        for (int i = 0; i < 3 * WORD_W; i++)
          send_sample(pick_sample(), i == 3 * WORD_W - 1);
      end else begin
        // phases may end mid-group, so settings also change inside a group
        random_config();
        for (int i = 0; i < 45; i++)
          send_sample(pick_sample(), $urandom_range(39) == 0);
      end
      settle();
    end

    if (planes.errors == 0 && planes.pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
